[rtl/assert_macros.svh]
// Assertion macros for the filter weight top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication check.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/lsf_pkg.sv]
// Shared types, constants and helpers of the filter weight datapath.
`timescale 1ns / 1ps
package lsf_pkg;
   localparam int ARG_W     = 21;
   localparam int DEN_W     = 39;
   localparam int REM_W     = 40;
   localparam int DIV_STEPS = 30;
   localparam int SINC_LAT  = 10 + DIV_STEPS;
   localparam int LANE_LAT  = SINC_LAT + 5;
   localparam int MERGE_LAT = 2;

   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [17:0] PI_Q16  = 18'd205887;
   localparam logic [30:0] C11     = 31'd3864;
   localparam logic [30:0] HORNER_C [0:4] = '{
      31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   typedef enum logic [1:0] {
      REG_INV_X = 2'd0,
      REG_INV_Y = 2'd1,
      REG_TAU   = 2'd2
   } reg_index_type;

   // Sign-magnitude Q30 factor; neg is never set on a zero magnitude.
   typedef struct packed {
      logic        neg;
      logic [30:0] mag;
   } factor_type;

   // Unsigned Q30 product, truncated.
   function automatic logic [30:0] q30mul(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] p;
      p = {31'd0, a} * {31'd0, b};
      return p[60:30];
   endfunction
endpackage

[rtl/lsf_sinc.sv]
// Pipelined sin(pi a)/(pi a) unit: polynomial sine, then a restoring divider.
`timescale 1ns / 1ps
module lsf_sinc (
   input  logic                       clock,
   input  logic                       en,
   input  logic [lsf_pkg::ARG_W-1:0]  arg,
   output lsf_pkg::factor_type        res
);
   import lsf_pkg::*;

   logic [16:0]      t16;
   logic [30:0]      t_ff   [1:7];
   logic [30:0]      t2_ff  [2:6];
   logic [30:0]      h_ff   [3:7];
   logic [DEN_W-1:0] den_ff [1:8];
   logic             neg_ff [1:8];
   logic [30:0]      s_ff;
   logic [30:0]      h_in   [3:7];
   logic [REM_W-1:0] rem0;

   logic [REM_W-1:0]     rem_ff  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] q_ff    [0:DIV_STEPS];
   logic [DEN_W-1:0]     dden_ff [0:DIV_STEPS];
   logic                 dneg_ff [0:DIV_STEPS];
   logic                 dsat_ff [0:DIV_STEPS];
   logic [REM_W-1:0]     r2_c    [1:DIV_STEPS];
   logic                 ge_c    [1:DIV_STEPS];
   factor_type           res_ff;
   logic [30:0]          mag_c;

   // Fold the phase into a quarter period
   always_comb begin
      if (arg[15:0] <= 16'd32768) begin
         t16 = {arg[15:0], 1'b0};
      end else begin
         t16 = {(16'd0 - arg[15:0]), 1'b0};
      end
   end

   // Horner terms
   always_comb begin
      h_in[3] = HORNER_C[0] - q30mul(t2_ff[2], C11);
      for (int k = 4; k <= 7; k++) begin
         h_in[k] = HORNER_C[k-3] - q30mul(t2_ff[k-1], h_ff[k-1]);
      end
   end

   assign rem0 = {7'd0, s_ff, 2'b00};

   // Advance the sine stages
   always_ff @(posedge clock) begin
      if (en) begin
         t_ff[1]   <= {t16, 14'd0};
         neg_ff[1] <= arg[16];
         den_ff[1] <= {18'd0, arg} * {21'd0, PI_Q16};
         for (int k = 2; k <= 7; k++) t_ff[k] <= t_ff[k-1];
         for (int k = 2; k <= 8; k++) begin
            den_ff[k] <= den_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         t2_ff[2] <= q30mul(t_ff[1], t_ff[1]);
         for (int k = 3; k <= 6; k++) t2_ff[k] <= t2_ff[k-1];
         for (int k = 3; k <= 7; k++) h_ff[k] <= h_in[k];
         s_ff <= q30mul(t_ff[7], h_ff[7]);
      end
   end

   // One quotient bit per stage
   always_comb begin
      for (int k = 1; k <= DIV_STEPS; k++) begin
         r2_c[k] = {rem_ff[k-1][REM_W-2:0], 1'b0};
         ge_c[k] = r2_c[k] >= {1'b0, dden_ff[k-1]};
      end
   end

   // Advance the divider stages
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem0;
         q_ff[0]    <= '0;
         dden_ff[0] <= den_ff[8];
         dneg_ff[0] <= neg_ff[8];
         dsat_ff[0] <= rem0 >= {1'b0, den_ff[8]};
         for (int k = 1; k <= DIV_STEPS; k++) begin
            rem_ff[k]  <= ge_c[k] ? (r2_c[k] - {1'b0, dden_ff[k-1]}) : r2_c[k];
            q_ff[k]    <= {q_ff[k-1][DIV_STEPS-2:0], ge_c[k]};
            dden_ff[k] <= dden_ff[k-1];
            dneg_ff[k] <= dneg_ff[k-1];
            dsat_ff[k] <= dsat_ff[k-1];
         end
         res_ff <= '{neg: dneg_ff[DIV_STEPS] && (mag_c != 31'd0), mag: mag_c};
      end
   end

   // Clamp the quotient to one
   assign mag_c = dsat_ff[DIV_STEPS] ? ONE_Q30 : {1'b0, q_ff[DIV_STEPS]};
   assign res   = res_ff;
endmodule

[rtl/lsf_lane.sv]
// One coordinate lane: scale the offset, evaluate both sinc terms, multiply.
`timescale 1ns / 1ps
module lsf_lane (
   input  logic                clock,
   input  logic                en,
   input  logic [15:0]         offset,
   input  logic [15:0]         inv_width,
   input  logic [15:0]         tau,
   output lsf_pkg::factor_type fac
);
   import lsf_pkg::*;

   logic [16:0]      mag;
   logic [32:0]      p1_ff;
   logic [22:0]      u_c;
   logic [16:0]      ub_ff;
   logic             uzb_ff, ufb_ff;
   logic [32:0]      ut_ff;
   logic [ARG_W-1:0] usinc_ff, vsinc_ff;
   logic             uz_ff [0:SINC_LAT];
   logic             uf_ff [0:SINC_LAT];
   logic             vz_ff [0:SINC_LAT];
   factor_type       su, sv;
   logic [30:0]      bmag;
   logic             bneg;
   logic [61:0]      prod_ff;
   logic             psgn_ff, puz_ff, puf_ff;
   logic [30:0]      m_c;
   factor_type       fac_ff;

   // Offset magnitude
   assign mag = offset[15] ? (17'h10000 - {1'b0, offset}) : {1'b0, offset};
   assign u_c = p1_ff[32:10];

   // Scale and window stages
   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= {16'd0, mag} * {17'd0, inv_width};
         ub_ff    <= u_c[16:0];
         uzb_ff   <= u_c == 23'd0;
         ufb_ff   <= u_c > 23'd65536;
         ut_ff    <= {16'd0, u_c[16:0]} * {17'd0, tau};
         usinc_ff <= {4'd0, ub_ff};
         vsinc_ff <= ut_ff[32:12];
         uz_ff[0] <= uzb_ff;
         uf_ff[0] <= ufb_ff;
         vz_ff[0] <= ut_ff[32:12] == 21'd0;
         for (int k = 1; k <= SINC_LAT; k++) begin
            uz_ff[k] <= uz_ff[k-1];
            uf_ff[k] <= uf_ff[k-1];
            vz_ff[k] <= vz_ff[k-1];
         end
      end
   end

   lsf_sinc u_sinc_u (.clock(clock), .en(en), .arg(usinc_ff), .res(su));
   lsf_sinc u_sinc_v (.clock(clock), .en(en), .arg(vsinc_ff), .res(sv));

   // A zero window argument counts as one
   assign bmag = vz_ff[SINC_LAT] ? ONE_Q30 : sv.mag;
   assign bneg = vz_ff[SINC_LAT] ? 1'b0 : sv.neg;
   assign m_c  = prod_ff[60:30];

   // Product and special cases
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {31'd0, su.mag} * {31'd0, bmag};
         psgn_ff <= su.neg ^ bneg;
         puz_ff  <= uz_ff[SINC_LAT];
         puf_ff  <= uf_ff[SINC_LAT];
         if (puz_ff) begin
            fac_ff <= '{neg: 1'b0, mag: ONE_Q30};
         end else if (puf_ff) begin
            fac_ff <= '{neg: 1'b0, mag: 31'd0};
         end else begin
            fac_ff <= '{neg: psgn_ff && (m_c != 31'd0), mag: m_c};
         end
      end
   end

   assign fac = fac_ff;
endmodule

[rtl/lsf_merge.sv]
// Merge stage: multiply the two lane factors, round and saturate to Q1.15.
`timescale 1ns / 1ps
module lsf_merge (
   input  logic                clock,
   input  logic                en,
   input  lsf_pkg::factor_type fx,
   input  lsf_pkg::factor_type fy,
   output logic signed [15:0]  weight
);
   import lsf_pkg::*;

   logic [61:0] prod_ff;
   logic        sgn_ff;
   logic [30:0] m;
   logic [31:0] sum;
   logic [16:0] rnd;
   logic        neg;
   logic [15:0] w_in;
   logic [15:0] w_ff;

   // Round half away from zero, then saturate
   assign m   = prod_ff[60:30];
   assign sum = {1'b0, m} + 32'd16384;
   assign rnd = sum[31:15];
   assign neg = sgn_ff && (m != 31'd0);

   always_comb begin
      if (neg) begin
         w_in = 16'((17'd0 - rnd));
      end else if (rnd >= 17'd32768) begin
         w_in = 16'h7FFF;
      end else begin
         w_in = rnd[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= {31'd0, fx.mag} * {31'd0, fy.mag};
         sgn_ff  <= fx.neg ^ fy.neg;
         w_ff    <= w_in;
      end
   end

   assign weight = w_ff;
endmodule

[rtl/lanczos_sinc_filter_weight.sv]
// Separable Lanczos windowed sinc weight: two lanes, a merge stage and an output skid.
//
// Usage: present an offset pair on req_x_offset / req_y_offset with req_valid;
// the word is taken at an edge where req_valid is high and req_stall low.
// One weight word leaves on rsp_weight with rsp_valid for every pair taken,
// in order. A new pair may be taken every cycle.
// Pipeline from acceptance to rsp_valid: two scale stages, a window
// stage, 40 sinc stages of which 30 are the one-bit-per-stage divider, two lane
// product stages, two merge stages and the output register.
// Throughput: one pair per cycle, limited by nothing but the output side.
// Stall: the output register plus one skid word absorb a receiver stall;
// req_stall rises once the skid word is full, freezing the whole pipeline.
// Reset (synchronous, active high) empties the pipeline and output, and sets
// inv_x_width = inv_y_width = 4096 and window_tau = 12288.
// Registers on the APB port: 0x0 inv_x_width, 0x4 inv_y_width, 0x8 window_tau.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lanczos_sinc_filter_weight (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_x_offset,
   input  logic signed [15:0] req_y_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_weight,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [3:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import lsf_pkg::*;

   localparam int PIPE_LAT = LANE_LAT + MERGE_LAT;

   logic [15:0]         inv_x_ff, inv_y_ff, tau_ff;
   logic                wr_en;
   logic                en;
   logic [PIPE_LAT-1:0] vld_ff;
   factor_type          fx, fy;
   logic signed [15:0]  merge_w;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   logic signed [15:0]  rsp_w_ff, rsp_w_in;
   logic signed [15:0]  skid_w_ff, skid_w_in;
   logic                arrive, take;

   // Register writes and reads
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_x_ff <= 16'd4096;
         inv_y_ff <= 16'd4096;
         tau_ff   <= 16'd12288;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_INV_X: inv_x_ff <= pwdata[15:0];
            REG_INV_Y: inv_y_ff <= pwdata[15:0];
            REG_TAU:   tau_ff   <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_INV_X: prdata = {16'd0, inv_x_ff};
         REG_INV_Y: prdata = {16'd0, inv_y_ff};
         REG_TAU:   prdata = {16'd0, tau_ff};
         default:   prdata = 32'd0;
      endcase
   end

   // Pipeline moves while the skid word is free
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   lsf_lane u_lane_x (.clock(clock), .en(en), .offset(req_x_offset),
                      .inv_width(inv_x_ff), .tau(tau_ff), .fac(fx));
   lsf_lane u_lane_y (.clock(clock), .en(en), .offset(req_y_offset),
                      .inv_width(inv_y_ff), .tau(tau_ff), .fac(fy));
   lsf_merge u_merge (.clock(clock), .en(en), .fx(fx), .fy(fy), .weight(merge_w));

   // Output register and skid word
   assign arrive = en && vld_ff[PIPE_LAT-1];
   assign take   = rsp_valid_ff && !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_w_in      = rsp_w_ff;
      skid_w_in     = skid_w_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_w_in      = skid_w_ff;
            skid_valid_in = 1'b0;
         end
      end else if (arrive) begin
         if (!rsp_valid_ff || take) begin
            rsp_w_in     = merge_w;
            rsp_valid_in = 1'b1;
         end else begin
            skid_w_in     = merge_w;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_w_ff  <= rsp_w_in;
      skid_w_ff <= skid_w_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_w_ff;

   // Checks on the output buffering
   `ASSERT_IMPL(a_skid_behind_rsp, clock, reset, skid_valid_ff, rsp_valid_ff, "skid word without output word")
   `ASSERT_NEXT(a_skid_fills, clock, reset, rsp_valid_ff && rsp_stall && !skid_valid_ff && vld_ff[PIPE_LAT-1], skid_valid_ff, "stalled arrival lost")
   `ASSERT_NEXT(a_skid_holds, clock, reset, skid_valid_ff && rsp_stall, skid_valid_ff && rsp_valid_ff, "skid word dropped under stall")
endmodule
